// ===== sv/rbbl_pkg.sv =====
// ----------------------------------------------------------------------------
// rbbl_pkg
// Types and constants shared by the blinking, breathing LED block.
// ----------------------------------------------------------------------------
package rbbl_pkg;

   // Register indexes on the CSR port
   localparam logic [1:0] CSR_BRIGHT_LOW     = 2'd0;
   localparam logic [1:0] CSR_BRIGHT_HIGH    = 2'd1;
   localparam logic [1:0] CSR_OPEN_GAP_FLOOR = 2'd2;

   // Galois LFSR taps and the brightness ramp step
   localparam logic [7:0] LFSR_TAPS = 8'hF0;
   localparam logic [7:0] LEVEL_STEP = 8'd2;

   // Reset values
   localparam logic [6:0] BRIGHT_LOW_RST     = 7'd16;
   localparam logic [7:0] BRIGHT_HIGH_RST    = 8'd128;
   localparam logic [5:0] OPEN_GAP_FLOOR_RST = 6'd32;
   localparam logic [7:0] NOISE_RST          = 8'd251;  // seed 23 advanced once
   localparam logic [7:0] BLINK_TIMER_RST    = 8'd55;   // (23 & 0x3F) | 32
   localparam logic [7:0] LEVEL_RST          = 8'd128;

   // Configuration registers
   typedef struct packed {
      logic [6:0] bright_low;
      logic [7:0] bright_high;
      logic [5:0] open_gap_floor;
   } cfg_type;

   // Animation state
   typedef struct packed {
      logic [7:0] noise;
      logic [7:0] blink_timer;
      logic       awake;
      logic [7:0] level;
      logic       rising;
   } anim_type;

   // One result
   typedef struct packed {
      logic [7:0] pwm_duty;
      logic       led_enable;
      logic       blink_event;
   } result_type;

   // One step of the Galois LFSR: shift right, fold taps in on a one out
   function automatic logic [7:0] lfsr_next(input logic [7:0] v);
      logic [7:0] s;
      s = {1'b0, v[7:1]};
      if (v[0]) begin
         s = s ^ LFSR_TAPS;
      end
      return s;
   endfunction

endpackage

// ===== sv/rbbl_step.sv =====
// ----------------------------------------------------------------------------
// rbbl_step
// Next-state logic for one tick: blink timer, eye toggle, LFSR and ramp.
// ----------------------------------------------------------------------------
module rbbl_step
   import rbbl_pkg::*;
(
   input  cfg_type    cfg,
   input  anim_type   cur,
   input  logic       tick,
   output anim_type   nxt,
   output result_type res
);

   logic [7:0] timer_dec;
   logic [7:0] level_up;
   logic [7:0] level_dn;
   logic       toggle;

   assign timer_dec = cur.blink_timer - 8'd1;
   assign level_up  = cur.level + LEVEL_STEP;
   assign level_dn  = cur.level - LEVEL_STEP;
   assign toggle    = tick && (timer_dec == 8'd0);

   // Blink and ramp update
   always_comb begin
      nxt = cur;
      if (tick) begin
         nxt.blink_timer = timer_dec;
         if (toggle) begin
            if (cur.awake) begin
               // closing: short shut of one or two ticks
               nxt.awake       = 1'b0;
               nxt.blink_timer = {7'd0, cur.noise[0]} + 8'd1;
            end else begin
               // opening: random gap with a floor, then advance the noise
               nxt.awake       = 1'b1;
               nxt.blink_timer = {2'b00, cur.noise[5:0] | cfg.open_gap_floor};
               nxt.noise       = lfsr_next(cur.noise);
            end
         end else if (cur.rising) begin
            nxt.level = level_up;
            if (level_up >= cfg.bright_high) begin
               nxt.rising = 1'b0;
            end
         end else begin
            nxt.level = level_dn;
            if (level_dn <= {1'b0, cfg.bright_low}) begin
               nxt.rising = 1'b1;
            end
         end
      end
   end

   assign res.pwm_duty    = nxt.level;
   assign res.led_enable  = nxt.awake;
   assign res.blink_event = toggle;

endmodule

// ===== sv/random_blink_breathing_led_top.sv =====
// ----------------------------------------------------------------------------
// random_blink_breathing_led_top
// Randomly blinking, breathing LED: one duty/enable result per request.
// ----------------------------------------------------------------------------
// Each request carries a timer tick flag and gives exactly one response
// carrying the PWM duty, the LED enable and a blink flag. A request is
// taken every cycle the response register is free or being drained, so the
// block sustains one tick per clock; the response is registered and
// appears in the cycle after the request is taken. The CSR port is always
// ready; writes to indexes past the last register are ignored. Registers
// should only be written while idle.
// ----------------------------------------------------------------------------
module random_blink_breathing_led_top
   import rbbl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_tick,
   // response channel
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_pwm_duty,
   output logic       rsp_led_enable,
   output logic       rsp_blink_event,
   // configuration channel
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   cfg_type    cfg_ff;
   anim_type   anim_ff;
   anim_type   anim_in;
   result_type res_ff;
   result_type res_in;
   logic       rsp_valid_ff;
   logic       req_take;

   assign csr_ready = 1'b1;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bright_low     <= BRIGHT_LOW_RST;
         cfg_ff.bright_high    <= BRIGHT_HIGH_RST;
         cfg_ff.open_gap_floor <= OPEN_GAP_FLOOR_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_BRIGHT_LOW:     cfg_ff.bright_low     <= csr_wdata[6:0];
            CSR_BRIGHT_HIGH:    cfg_ff.bright_high    <= csr_wdata;
            CSR_OPEN_GAP_FLOOR: cfg_ff.open_gap_floor <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   // Per-tick update
   rbbl_step u_step (
      .cfg  (cfg_ff),
      .cur  (anim_ff),
      .tick (req_tick),
      .nxt  (anim_in),
      .res  (res_in)
   );

   // Animation state
   always_ff @(posedge clock) begin
      if (reset) begin
         anim_ff.noise       <= NOISE_RST;
         anim_ff.blink_timer <= BLINK_TIMER_RST;
         anim_ff.awake       <= 1'b1;
         anim_ff.level       <= LEVEL_RST;
         anim_ff.rising      <= 1'b0;
      end else if (req_take) begin
         anim_ff <= anim_in;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_ready) begin
         rsp_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pwm_duty    = res_ff.pwm_duty;
   assign rsp_led_enable  = res_ff.led_enable;
   assign rsp_blink_event = res_ff.blink_event;

endmodule
